@@ hdl/ttf_pkg.sv @@
// Shared types and constants for the triangle tangent frame unit.
package ttf_pkg;

  localparam int unsigned PosW = 32;
  localparam int unsigned UvW  = 16;
  localparam int unsigned UvFracBits = 12;       // texture coordinate fraction bits
  localparam int unsigned DpW  = PosW + 1;       // position delta
  localparam int unsigned DuvW = UvW + 1;        // uv delta
  localparam int unsigned DetW = 2 * DuvW + 1;   // determinant
  localparam int unsigned NumW = DpW + DuvW + 1; // numerator (51 bits)
  localparam int unsigned QueueDepth = 2;

  // One finished triangle: deltas handed from front to back.
  typedef struct packed {
    logic signed [DpW-1:0]  dp0_x, dp0_y, dp0_z;
    logic signed [DpW-1:0]  dp1_x, dp1_y, dp1_z;
    logic signed [DuvW-1:0] du0, dv0, du1, dv1;
  } tri_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DET,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } back_state_e;

endpackage

@@ hdl/ttf_front.sv @@
// Front end: collects three vertices and forms triangle deltas.
module ttf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [127:0]        in_data_i,
  output logic                tri_valid_o,
  input  logic                tri_ready_i,
  output ttf_pkg::tri_t       tri_o
);
  import ttf_pkg::*;

  logic [1:0] corner_q, corner_d;
  logic signed [PosW-1:0] p0x_q, p0y_q, p0z_q, p1x_q, p1y_q, p1z_q;
  logic signed [UvW-1:0]  u0_q, v0_q, u1_q, v1_q;
  logic signed [PosW-1:0] px, py, pz;
  logic signed [UvW-1:0]  u, v;
  logic accept;

  assign px = in_data_i[31:0];
  assign py = in_data_i[63:32];
  assign pz = in_data_i[95:64];
  assign u  = in_data_i[111:96];
  assign v  = in_data_i[127:112];

  // corner 2 needs room downstream
  assign in_ready_o  = (corner_q != 2'd2) || tri_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign tri_valid_o = in_valid_i && (corner_q == 2'd2);

  // deltas relative to corner 0
  always_comb begin
    tri_o.dp0_x = DpW'(p1x_q) - DpW'(p0x_q);
    tri_o.dp0_y = DpW'(p1y_q) - DpW'(p0y_q);
    tri_o.dp0_z = DpW'(p1z_q) - DpW'(p0z_q);
    tri_o.dp1_x = DpW'(px) - DpW'(p0x_q);
    tri_o.dp1_y = DpW'(py) - DpW'(p0y_q);
    tri_o.dp1_z = DpW'(pz) - DpW'(p0z_q);
    tri_o.du0   = DuvW'(u1_q) - DuvW'(u0_q);
    tri_o.dv0   = DuvW'(v1_q) - DuvW'(v0_q);
    tri_o.du1   = DuvW'(u) - DuvW'(u0_q);
    tri_o.dv1   = DuvW'(v) - DuvW'(v0_q);
  end

  always_comb begin
    corner_d = corner_q;
    if (accept) begin
      corner_d = (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= 2'd0;
    end else begin
      corner_q <= corner_d;
    end
  end

  // held corners, payload only
  always_ff @(posedge clk_i) begin
    if (accept && corner_q == 2'd0) begin
      p0x_q <= px; p0y_q <= py; p0z_q <= pz; u0_q <= u; v0_q <= v;
    end
    if (accept && corner_q == 2'd1) begin
      p1x_q <= px; p1y_q <= py; p1z_q <= pz; u1_q <= u; v1_q <= v;
    end
  end
endmodule

@@ hdl/ttf_queue.sv @@
// Small FIFO of triangles between front and back.
module ttf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  ttf_pkg::tri_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output ttf_pkg::tri_t rd_data_o
);
  import ttf_pkg::*;

  tri_t       mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'(QueueDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

@@ hdl/ttf_back.sv @@
// Back end: determinant, numerators and six serial divides with saturation.
module ttf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tri_valid_i,
  output logic          tri_ready_o,
  input  ttf_pkg::tri_t tri_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [199:0]  out_data_o
);
  import ttf_pkg::*;

  localparam int unsigned NSh  = NumW + 14;  // shifted numerator magnitude
  localparam int unsigned StW  = $clog2(NSh + 1);

  back_state_e st_q, st_d;
  tri_t                    t_q;
  logic signed [DetW-1:0]  det_q;
  logic signed [NumW-1:0]  num_q [6];
  logic [2:0]              idx_q;
  logic [1:0]              ph_q;
  logic [NSh-1:0]          n_q;
  logic [DetW-1:0]         d_q;
  logic [DetW:0]           r_q;
  logic [StW-1:0]          bit_q;
  logic                    neg_q;
  logic [NSh-1:0]          qacc_q;
  logic [31:0]             res_q [6];
  logic                    degen_q;
  logic signed [NumW-1:0]  pa_q, pb_q;

  // multiplier operand select for numerators (one product pair per numerator)
  logic signed [DpW-1:0]  ma, mc;
  logic signed [DuvW-1:0] mb, md;
  always_comb begin
    ma = t_q.dp0_x; mc = t_q.dp1_x;
    unique case (idx_q)
      3'd0, 3'd3: begin ma = t_q.dp0_x; mc = t_q.dp1_x; end
      3'd1, 3'd4: begin ma = t_q.dp0_y; mc = t_q.dp1_y; end
      default:    begin ma = t_q.dp0_z; mc = t_q.dp1_z; end
    endcase
    if (idx_q < 3'd3) begin
      mb = t_q.dv1; md = t_q.dv0;          // dp0*dv1 - dp1*dv0
    end else begin
      mb = -t_q.du1; md = -t_q.du0;        // dp1*du0 - dp0*du1
    end
  end

  logic [NumW-1:0] num_abs;
  logic [DetW-1:0] det_abs;
  logic [DetW:0]   r_sh, r_sub;
  assign num_abs = num_q[idx_q][NumW-1] ? NumW'(-num_q[idx_q]) : NumW'(num_q[idx_q]);
  assign det_abs = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
  assign r_sh  = {r_q[DetW-1:0], n_q[NSh-1]};
  assign r_sub = r_sh - {1'b0, d_q};

  // saturate magnitude with sign
  logic [31:0] sat_val;
  always_comb begin
    if (neg_q) begin
      sat_val = (qacc_q > NSh'(64'h8000_0000)) ? 32'h8000_0000
                : 32'(-qacc_q);
    end else begin
      sat_val = (qacc_q > NSh'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qacc_q[31:0];
    end
  end

  assign tri_ready_o = (st_q == ST_IDLE);
  assign out_valid_o = (st_q == ST_OUT);
  always_comb begin
    out_data_o = '0;
    for (int k = 0; k < 6; k++) out_data_o[k*32 +: 32] = res_q[k];
    out_data_o[192] = degen_q;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (tri_valid_i) st_d = ST_DET;
      ST_DET:  if (ph_q == 2'd2) st_d = (det_q == '0) ? ST_OUT : ST_MUL;
      ST_MUL:  if (ph_q == 2'd1 && idx_q == 3'd5) st_d = ST_DIV;
      ST_DIV:  if (ph_q == 2'd2 && idx_q == 3'd5) st_d = ST_OUT;
      ST_OUT:  if (out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ph_q <= 2'd0;
      idx_q <= 3'd0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        ST_IDLE: begin ph_q <= 2'd0; idx_q <= 3'd0; end
        ST_DET:  ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
        ST_MUL: begin
          if (ph_q == 2'd1) begin
            ph_q <= 2'd0;
            idx_q <= (idx_q == 3'd5) ? 3'd0 : idx_q + 3'd1;
          end else ph_q <= 2'd1;
        end
        ST_DIV: begin
          if (ph_q == 2'd0) ph_q <= 2'd1;
          else if (ph_q == 2'd1) begin
            if (bit_q == StW'(1)) ph_q <= 2'd2;
          end else begin
            ph_q <= 2'd0;
            idx_q <= (idx_q == 3'd5) ? 3'd0 : idx_q + 3'd1;
          end
        end
        default: ph_q <= 2'd0;
      endcase
    end
  end

  // datapath, payload registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: if (tri_valid_i) t_q <= tri_i;
      ST_DET: begin
        // ph0: products, ph1: difference, ph2: degenerate check
        if (ph_q == 2'd0) begin
          pa_q <= NumW'(t_q.du0 * t_q.dv1);
          pb_q <= NumW'(t_q.dv0 * t_q.du1);
        end else if (ph_q == 2'd1) begin
          det_q <= DetW'(pa_q - pb_q);
        end else begin
          degen_q <= (det_q == '0);
          if (det_q == '0) for (int k = 0; k < 6; k++) res_q[k] <= '0;
        end
      end
      ST_MUL: begin
        if (ph_q == 2'd0) begin
          pa_q <= NumW'(ma * mb);
          pb_q <= NumW'(mc * md);
        end else begin
          num_q[idx_q] <= pa_q - pb_q;
        end
      end
      ST_DIV: begin
        if (ph_q == 2'd0) begin
          n_q    <= {num_abs, {14{1'b0}}} >> (14 - UvFracBits);
          d_q    <= det_abs;
          r_q    <= '0;
          qacc_q <= '0;
          bit_q  <= StW'(NSh);
          neg_q  <= num_q[idx_q][NumW-1] ^ det_q[DetW-1];
        end else if (ph_q == 2'd1) begin
          // one restoring step per cycle
          n_q   <= n_q << 1;
          bit_q <= bit_q - StW'(1);
          if (!r_sub[DetW]) begin
            r_q <= r_sub;
            qacc_q <= {qacc_q[NSh-2:0], 1'b1};
          end else begin
            r_q <= r_sh;
            qacc_q <= {qacc_q[NSh-2:0], 1'b0};
          end
        end else begin
          res_q[idx_q] <= sat_val;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ hdl/triangle_tangent_frame.sv @@
// Top level of the triangle tangent frame unit.
//  channel | dir | fields (low bit up)
//  s_axis  | in  | pos_x, pos_y, pos_z, tex_u, tex_v (128 bits)
//  m_axis  | out | tangent_x..z, bitangent_x..z, degenerate (200 bits)
// Corners 0 and 1 are always accepted; corner 2 needs a free slot in the
// two-entry queue, else s_axis_tready drops until one opens.
// Back end per triangle: load, the determinant, the six numerators, the six
// serial divides, then the output beat; a zero determinant goes from the
// determinant straight to the output beat.
// m_axis_tready low holds the back end; the queue then fills and the input stalls.
// Reset clears the corner count, queue and back-end state.
module triangle_tangent_frame (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata    // tangent xyz, bitangent xyz, degenerate
);
  import ttf_pkg::*;

  tri_t f_tri, b_tri;
  logic f_valid, f_ready, b_valid, b_ready;

  ttf_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .tri_valid_o(f_valid), .tri_ready_i(f_ready), .tri_o(f_tri)
  );

  ttf_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_tri),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_tri)
  );

  ttf_back u_back (
    .clk_i, .rst_ni,
    .tri_valid_i(b_valid), .tri_ready_o(b_ready), .tri_i(b_tri),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );
endmodule

@@ sim/triangle_tangent_frame_checker.sv @@
// Checker for the triangle tangent frame unit: watches both channels, predicts and compares.
module triangle_tangent_frame_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [199:0] m_axis_tdata,   // tangent xyz, bitangent xyz, degenerate
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned UvFrac = 12;

  // Packed from the top down, so tan_x lands in the lowest bits as on the bus
  typedef struct packed {
    logic        degenerate;
    logic [31:0] bitan_z, bitan_y, bitan_x;
    logic [31:0] tan_z, tan_y, tan_x;
  } frame_t;

  frame_t  frame_q[$];
  int      corner_idx;
  longint  corner_pos[2][3];
  longint  corner_uv[2][2];

  // num * 2^UvFrac / det, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] scaled_quotient(longint num, longint det);
    logic [63:0]  an, ad;
    logic [127:0] q;
    logic         neg;
    neg = (num < 0) != (det < 0);
    an  = (num < 0) ? -num : num;
    ad  = (det < 0) ? -det : det;
    q   = ({64'd0, an} << UvFrac) / {64'd0, ad};
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'(-q[31:0]);
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // Take one vertex; on the third corner queue the frame it yields
  task automatic take_vertex(logic [127:0] d);
    longint p[3], dp0[3], dp1[3];
    longint u, v, du0, dv0, du1, dv1, det;
    frame_t f;
    p[0] = longint'($signed(d[31:0]));
    p[1] = longint'($signed(d[63:32]));
    p[2] = longint'($signed(d[95:64]));
    u    = longint'($signed(d[111:96]));
    v    = longint'($signed(d[127:112]));
    if (corner_idx < 2) begin
      corner_pos[corner_idx] = p;
      corner_uv[corner_idx][0] = u;
      corner_uv[corner_idx][1] = v;
      corner_idx++;
      return;
    end
    corner_idx = 0;
    du0 = corner_uv[1][0] - corner_uv[0][0];
    dv0 = corner_uv[1][1] - corner_uv[0][1];
    du1 = u - corner_uv[0][0];
    dv1 = v - corner_uv[0][1];
    det = du0 * dv1 - dv0 * du1;
    f = '0;
    if (det == 0) begin
      f.degenerate = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        dp0[k] = corner_pos[1][k] - corner_pos[0][k];
        dp1[k] = p[k] - corner_pos[0][k];
      end
      f.tan_x   = scaled_quotient(dp0[0] * dv1 - dp1[0] * dv0, det);
      f.tan_y   = scaled_quotient(dp0[1] * dv1 - dp1[1] * dv0, det);
      f.tan_z   = scaled_quotient(dp0[2] * dv1 - dp1[2] * dv0, det);
      f.bitan_x = scaled_quotient(dp1[0] * du0 - dp0[0] * du1, det);
      f.bitan_y = scaled_quotient(dp1[1] * du0 - dp0[1] * du1, det);
      f.bitan_z = scaled_quotient(dp1[2] * du0 - dp0[2] * du1, det);
    end
    frame_q.push_back(f);
  endtask

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    errors_o++;
  endtask

  // Results are compared before this edge's vertex is taken
  always @(posedge clk_i or negedge rst_ni) begin
    frame_t f, g;
    if (!rst_ni) begin
      corner_idx = 0;
      frame_q.delete();
      errors_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        g = m_axis_tdata[192:0];
        if (frame_q.size() == 0) begin
          report("unexpected beat", 32'd0, g.tan_x);
        end else begin
          f = frame_q.pop_front();
          if (g.tan_x !== f.tan_x)     report("tangent_x", f.tan_x, g.tan_x);
          if (g.tan_y !== f.tan_y)     report("tangent_y", f.tan_y, g.tan_y);
          if (g.tan_z !== f.tan_z)     report("tangent_z", f.tan_z, g.tan_z);
          if (g.bitan_x !== f.bitan_x) report("bitangent_x", f.bitan_x, g.bitan_x);
          if (g.bitan_y !== f.bitan_y) report("bitangent_y", f.bitan_y, g.bitan_y);
          if (g.bitan_z !== f.bitan_z) report("bitangent_z", f.bitan_z, g.bitan_z);
          if (g.degenerate !== f.degenerate)
            report("degenerate", 32'(f.degenerate), 32'(g.degenerate));
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_vertex(s_axis_tdata);
    end
    pending_o = frame_q.size();
  end
endmodule

@@ sim/triangle_tangent_frame_tb.sv @@
// Testbench top for the triangle tangent frame unit: stimulus, stalls and verdict.
module triangle_tangent_frame_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumTris     = 550;
  localparam int QuietFrom   = 500;
  localparam int StallAt     = 150;
  localparam int PauseAt     = 300;
  localparam int WatchLimit  = 20000;
  localparam int DrainCycles = 500;

  // Vertex in bus order: first member lands in the top bits
  typedef struct packed {
    logic [15:0] v, u;
    logic [31:0] z, y, x;
  } vtx_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  int           errors, pending;
  int           tris_sent = 0;
  int           idle_cycles = 0;
  bit           stall_done = 0;

  triangle_tangent_frame DUT (.*);

  triangle_tangent_frame_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: short random stalls, one long hold-off, none near the end
  initial begin
    repeat (4) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!stall_done && tris_sent >= StallAt) begin
        stall_done = 1;
        m_axis_tready <= 1'b0;
        repeat (1500) @(posedge clk_i);
      end else if (tris_sent < QuietFrom && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(posedge clk_i);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_vertex(vtx_word_t vx);
    if (tris_sent < QuietFrom && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= vx;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic send_triangle(vtx_word_t a, vtx_word_t b, vtx_word_t c);
    send_vertex(a);
    send_vertex(b);
    send_vertex(c);
    tris_sent++;
  endtask

  function automatic vtx_word_t vtx(int x, int y, int z, int u, int v);
    return {16'(v), 16'(u), 32'(z), 32'(y), 32'(x)};
  endfunction

  function automatic vtx_word_t random_vertex(bit narrow);
    vtx_word_t r;
    r.x = $urandom; r.y = $urandom; r.z = $urandom;
    r.u = $urandom; r.v = $urandom;
    if (narrow) begin
      r.x = 32'($signed(r.x[21:0]));
      r.y = 32'($signed(r.y[21:0]));
      r.z = 32'($signed(r.z[21:0]));
    end
    return r;
  endfunction

  // Random triangle: general, narrow positions, tiny uv spans (saturation) or degenerate uv
  task automatic random_triangle();
    vtx_word_t a, b, c;
    int mode;
    mode = $urandom_range(0, 9);
    a = random_vertex(mode >= 7);
    b = random_vertex(mode >= 7);
    c = random_vertex(mode >= 7);
    if (mode == 4 || mode == 5) begin
      b.u = a.u + 16'($urandom_range(0, 6)) - 16'd3;
      b.v = a.v + 16'($urandom_range(0, 6)) - 16'd3;
      c.u = a.u + 16'($urandom_range(0, 6)) - 16'd3;
      c.v = a.v + 16'($urandom_range(0, 6)) - 16'd3;
    end else if (mode == 6) begin
      c.u = $urandom_range(0, 1) ? b.u : a.u;
      c.v = (c.u == b.u) ? b.v : a.v;
    end
    send_triangle(a, b, c);
  endtask

  initial begin
    int pmax, pmin, one;
    pmax = 32'h7FFF_FFFF;
    pmin = 32'h8000_0000;
    one  = 32'h0001_0000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unit frame, degenerate, extremes, saturation both ways
    send_triangle(vtx(0, 0, 0, 0, 0), vtx(one, 0, 0, 4096, 0), vtx(0, one, 0, 0, 4096));
    send_triangle(vtx(pmax, pmax, pmax, 0, 0), vtx(pmin, pmin, pmin, 0, 0),
                  vtx(pmax, pmin, pmax, 0, 0));
    send_triangle(vtx(pmin, pmin, pmin, -32768, -32768),
                  vtx(pmax, pmax, pmax, 32767, -32768),
                  vtx(pmax, pmax, pmax, -32768, 32767));
    send_triangle(vtx(pmin, pmin, pmin, 0, 0), vtx(pmax, pmax, pmax, 1, 0),
                  vtx(pmin, pmax, pmin, 0, 1));
    send_triangle(vtx(pmin, pmin, pmin, 0, 0), vtx(pmax, pmax, pmax, -1, 0),
                  vtx(pmin, pmax, pmin, 0, 1));
    send_triangle(vtx(one, -one, 7, 32767, 32767), vtx(-5, pmax, 0, -32768, 32767),
                  vtx(pmin, 3, one, 32767, -32768));
    send_triangle(vtx(1, 2, 3, 0, 0), vtx(4, 5, 6, 1, 1), vtx(7, 8, 9, 2, 2));
    send_triangle(vtx(pmax, pmin, 0, 100, 200), vtx(pmin, pmax, -1, 101, 200),
                  vtx(0, 0, pmax, 100, 199));

    // Random body with one full drain midway
    while (tris_sent < NumTris) begin
      if (tris_sent == PauseAt) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
        @(posedge clk_i);
      end
      random_triangle();
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
